FILE: hdl/bsm_pkg.sv
`timescale 1ns / 1ps
// Shared types and helpers for the bounding sphere merge block.
// No dependencies; the interfaces and the top level import this package.
package bsm_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned RadW    = 31;
    localparam int unsigned DeltaW  = 33;
    localparam int unsigned RootW   = 35;
    localparam int unsigned RadicW  = 70;
    localparam int unsigned RemW    = 38;
    localparam int unsigned CntW    = 7;
    localparam int unsigned NumAxes = 3;

    localparam logic [CntW-1:0] SqrLast  = CntW'(DeltaW - 1);
    localparam logic [CntW-1:0] RootLast = CntW'(RootW - 1);
    localparam logic [CntW-1:0] MulLast  = CntW'(RadW - 1);
    localparam logic [CntW-1:0] DivLast  = CntW'(63);

    localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
    localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
    localparam logic [RadW-1:0]          RadMax   = {RadW{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_ROOT,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_AXIS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                     start_req;
        logic signed [CoordW-1:0] center_x;
        logic signed [CoordW-1:0] center_y;
        logic signed [CoordW-1:0] center_z;
        logic [RadW-1:0]          sphere_radius;
    } t_in_word;

    typedef struct packed {
        logic signed [CoordW-1:0] merged_x;
        logic signed [CoordW-1:0] merged_y;
        logic signed [CoordW-1:0] merged_z;
        logic [RadW-1:0]          merged_radius;
        logic                     already_inside;
        logic                     saturated;
    } t_out_word;

    // Magnitude of a signed delta; the most negative value maps to 2^32.
    function automatic logic [DeltaW-1:0] mag_delta(input logic signed [DeltaW-1:0] v);
        mag_delta = v[DeltaW-1] ? DeltaW'(-v) : DeltaW'(v);
    endfunction

endpackage

FILE: hdl/bsm_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one input sphere word.
// Depends on bsm_pkg for the payload type.
interface bsm_in_if import bsm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bsm_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one merged sphere word.
// Depends on bsm_pkg for the payload type.
interface bsm_out_if import bsm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/bounding_sphere_merge_top.sv
`timescale 1ns / 1ps
// Running bounding sphere: each accepted word either restarts the sphere (start_req) or
// merges a new sphere into it, and yields one word with the updated sphere. A merge word
// first has a shift-add multiplier form the three squared deltas and a restoring square
// root give the distance; unless the new sphere lies inside the old one or contains it,
// per axis a multiply and a restoring divide then form the offset term. Input ready is
// high only while idle; a finished word waits in the output register, and the next word
// is taken meanwhile.
// Depends on bsm_pkg, bsm_in_if and bsm_out_if.
module bounding_sphere_merge_top
    import bsm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    bsm_in_if.sink    i_sph,
    bsm_out_if.source o_mrg
);

    t_state n_state, r_state;
    logic [1:0]      r_axis;
    logic [CntW-1:0] r_cnt;

    logic signed [CoordW-1:0] r_run [NumAxes];
    logic [RadW-1:0]          r_run_r;
    logic signed [CoordW-1:0] r_nc  [NumAxes];
    logic [RadW-1:0]          r_nr;
    logic signed [DeltaW-1:0] r_dlt [NumAxes];

    logic [RadicW-1:0] r_acc;
    logic [65:0]       r_mc;
    logic [DeltaW-1:0] r_mp;
    logic [RemW-1:0]   r_rem;
    logic [RootW-1:0]  r_root;
    logic [RadW-1:0]   r_rdm;
    logic              r_rneg;
    logic [RootW-1:0]  r_rad;

    logic signed [CoordW-1:0] r_res [NumAxes];
    logic [RadW-1:0]          r_res_r;
    logic                     r_inside;
    logic                     r_sat;

    t_out_word r_out;
    logic      r_ovalid;

    logic in_fire, out_load, step_last;

    // Handshake and sequencer control
    always_comb begin
        i_sph.ready = (r_state == ST_IDLE);
        in_fire     = i_sph.valid && i_sph.ready;
        out_load    = (r_state == ST_DONE) && (!r_ovalid || o_mrg.ready);
        unique case (r_state)
            ST_SQR:  step_last = (r_cnt == SqrLast);
            ST_ROOT: step_last = (r_cnt == RootLast);
            ST_MUL:  step_last = (r_cnt == MulLast);
            ST_DIV:  step_last = (r_cnt == DivLast);
            default: step_last = 1'b0;
        endcase
    end

    // Input deltas against the running sphere
    logic signed [DeltaW-1:0] in_dlt [NumAxes];
    always_comb begin
        in_dlt[0] = DeltaW'(i_sph.data.center_x) - DeltaW'(r_run[0]);
        in_dlt[1] = DeltaW'(i_sph.data.center_y) - DeltaW'(r_run[1]);
        in_dlt[2] = DeltaW'(i_sph.data.center_z) - DeltaW'(r_run[2]);
    end

    // Square root step
    logic [RemW-1:0] rt_rem2, rt_trial;
    logic            rt_ge;
    always_comb begin
        rt_rem2  = {r_rem[RemW-3:0], r_acc[RadicW-1 -: 2]};
        rt_trial = {1'b0, r_root, 2'b01};
        rt_ge    = (rt_rem2 >= rt_trial);
    end

    // Divide step
    logic [RootW+1:0] dv_rem2;
    logic             dv_ge;
    always_comb begin
        dv_rem2 = {r_rem[RootW:0], r_acc[63]};
        dv_ge   = (dv_rem2 >= {2'b00, r_root});
    end

    // Merge decision against the distance
    logic [RootW:0] dc_dn, dc_do, dc_sum;
    logic           dc_inside, dc_contains;
    always_comb begin
        dc_dn       = {1'b0, r_root} + (RootW+1)'(r_nr);
        dc_do       = {1'b0, r_root} + (RootW+1)'(r_run_r);
        dc_sum      = dc_do + (RootW+1)'(r_nr);
        dc_inside   = (dc_dn < (RootW+1)'(r_run_r));
        dc_contains = (dc_do <= (RootW+1)'(r_nr));
    end

    // Center for one axis: half of old + new + signed term, then clamp
    logic signed [RootW-1:0] ax_term, ax_sum, ax_half;
    logic signed [CoordW-1:0] ax_val;
    logic                     ax_sat;
    always_comb begin
        ax_term = (r_dlt[r_axis][DeltaW-1] ^ r_rneg) ? -RootW'(r_acc[RadW-1:0])
                                                    :  RootW'(r_acc[RadW-1:0]);
        ax_sum  = RootW'(r_run[r_axis]) + RootW'(r_nc[r_axis]) + ax_term;
        ax_half = ax_sum >>> 1;
        priority if (ax_half > RootW'(CoordMax)) begin
            ax_val = CoordMax;
            ax_sat = 1'b1;
        end else if (ax_half < RootW'(CoordMin)) begin
            ax_val = CoordMin;
            ax_sat = 1'b1;
        end else begin
            ax_val = ax_half[CoordW-1:0];
            ax_sat = 1'b0;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (in_fire) n_state = i_sph.data.start_req ? ST_DONE : ST_SQR;
            ST_SQR:    if (step_last && r_axis == 2'd2) n_state = ST_ROOT;
            ST_ROOT:   if (step_last) n_state = ST_DECIDE;
            ST_DECIDE: n_state = (dc_inside || dc_contains) ? ST_DONE : ST_MUL;
            ST_MUL:    if (step_last) n_state = ST_DIV;
            ST_DIV:    if (step_last) n_state = ST_AXIS;
            ST_AXIS:   n_state = (r_axis == 2'd2) ? ST_DONE : ST_MUL;
            ST_DONE:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_run_r  <= '0;
            for (int i = 0; i < NumAxes; i++) r_run[i] <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
                r_run_r  <= r_res_r;
                for (int i = 0; i < NumAxes; i++) r_run[i] <= r_res[i];
            end else if (o_mrg.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath: shared shift-add, root and divide registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_nc[0] <= i_sph.data.center_x;
                r_nc[1] <= i_sph.data.center_y;
                r_nc[2] <= i_sph.data.center_z;
                r_nr    <= i_sph.data.sphere_radius;
                for (int i = 0; i < NumAxes; i++) r_dlt[i] <= in_dlt[i];
                r_res[0] <= i_sph.data.center_x;
                r_res[1] <= i_sph.data.center_y;
                r_res[2] <= i_sph.data.center_z;
                r_res_r  <= i_sph.data.sphere_radius;
                r_inside <= 1'b0;
                r_sat    <= 1'b0;
                r_axis   <= '0;
                r_cnt    <= '0;
                r_acc    <= '0;
                r_mc     <= 66'(mag_delta(in_dlt[0]));
                r_mp     <= mag_delta(in_dlt[0]);
            end
            ST_SQR: begin
                if (r_mp[0]) r_acc <= r_acc + RadicW'(r_mc);
                if (step_last) begin
                    r_cnt  <= '0;
                    r_axis <= r_axis + 2'd1;
                    r_mc   <= 66'(mag_delta(r_dlt[r_axis + 2'd1]));
                    r_mp   <= mag_delta(r_dlt[r_axis + 2'd1]);
                    r_rem  <= '0;
                    r_root <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                    r_mc  <= {r_mc[64:0], 1'b0};
                    r_mp  <= {1'b0, r_mp[DeltaW-1:1]};
                end
            end
            ST_ROOT: begin
                r_acc  <= {r_acc[RadicW-3:0], 2'b00};
                r_rem  <= rt_ge ? rt_rem2 - rt_trial : rt_rem2;
                r_root <= {r_root[RootW-2:0], rt_ge};
                r_cnt  <= step_last ? '0 : r_cnt + 1'b1;
            end
            ST_DECIDE: begin
                r_axis <= '0;
                r_rad  <= dc_sum[RootW:1];
                r_rneg <= (r_nr < r_run_r);
                r_rdm  <= (r_nr < r_run_r) ? r_run_r - r_nr : r_nr - r_run_r;
                r_acc  <= '0;
                r_mc   <= 66'(mag_delta(r_dlt[0]));
                r_mp   <= (r_nr < r_run_r) ? DeltaW'(r_run_r - r_nr)
                                           : DeltaW'(r_nr - r_run_r);
                if (dc_inside) begin
                    r_inside <= 1'b1;
                    r_res    <= r_run;
                    r_res_r  <= r_run_r;
                end
            end
            ST_MUL: begin
                if (r_mp[0]) r_acc <= r_acc + RadicW'(r_mc);
                r_mc  <= {r_mc[64:0], 1'b0};
                r_mp  <= {1'b0, r_mp[DeltaW-1:1]};
                r_cnt <= step_last ? '0 : r_cnt + 1'b1;
                r_rem <= '0;
            end
            ST_DIV: begin
                r_acc <= {r_acc[RadicW-1:64], r_acc[62:0], dv_ge};
                r_rem <= dv_ge ? RemW'(dv_rem2 - {2'b00, r_root}) : RemW'(dv_rem2);
                r_cnt <= step_last ? '0 : r_cnt + 1'b1;
            end
            ST_AXIS: begin
                r_res[r_axis] <= ax_val;
                r_axis        <= r_axis + 2'd1;
                r_acc         <= '0;
                r_mc          <= 66'(mag_delta(r_dlt[r_axis + 2'd1]));
                r_mp          <= DeltaW'(r_rdm);
                if (r_axis == 2'd2) begin
                    r_res_r <= (r_rad > RootW'(RadMax)) ? RadMax : r_rad[RadW-1:0];
                    r_sat   <= r_sat | ax_sat | (r_rad > RootW'(RadMax));
                end else begin
                    r_sat <= r_sat | ax_sat;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    r_out.merged_x       <= r_res[0];
                    r_out.merged_y       <= r_res[1];
                    r_out.merged_z       <= r_res[2];
                    r_out.merged_radius  <= r_res_r;
                    r_out.already_inside <= r_inside;
                    r_out.saturated      <= r_sat;
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_mrg.valid = r_ovalid;
    assign o_mrg.data  = r_out;

    // Checks on the sequencer
    a_rise_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_DONE)
        else $error("output word raised outside the done state");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_root != '0)
        else $error("divide started with zero distance");

    a_inside_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_inside) |-> (r_res_r == r_run_r && r_res[0] == r_run[0]))
        else $error("kept sphere differs from running sphere");

    a_root_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROOT |-> r_cnt <= RootLast)
        else $error("root step count out of range");

endmodule
